// ----- hdl/selt_pkg.sv -----
// Package: types and constants for the shared/exclusive lock table.
package selt_pkg;
    localparam int NumTx  = 16;
    localparam int NumRes = 64;
    localparam int TxW    = $clog2(NumTx);
    localparam int ResW   = $clog2(NumRes);
    localparam int EntW   = 1 + TxW + 2 * NumTx;
    localparam int QDepth = 2;

    typedef enum logic [1:0] {
        CMD_SHARED  = 2'd0,
        CMD_EXCL    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_WAIT     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_QUERY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_READ, S_ACQ, S_SWEEP, S_OUT
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [TxW-1:0]    tx;
        logic [ResW-1:0]   res;
        logic              tx_ok;
        logic              res_ok;
    } t_job;

    typedef struct packed {
        logic               excl_valid;
        logic [TxW-1:0]     excl_owner;
        logic [NumTx-1:0]   shared_set;
        logic [NumTx-1:0]   waiter_set;
    } t_entry;
endpackage

// ----- hdl/selt_if.sv -----
// Interfaces: request and response channels.
interface selt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] tx_id;
    logic [5:0] resource_id;
    modport source (output valid, command, tx_id, resource_id, input ready);
    modport sink (input valid, command, tx_id, resource_id, output ready);
endinterface

interface selt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] wait_for_set;
    modport source (output valid, status, wait_for_set, input ready);
    modport sink (input valid, status, wait_for_set, output ready);
endinterface

// ----- hdl/selt_ram.sv -----
// Generic single-port-write RAM with registered read.
module selt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/selt_front.sv -----
// Front end: accepts requests, classifies them, queues jobs.
module selt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    selt_req_if.sink            req,
    output logic                o_job_valid,
    output selt_pkg::t_job      o_job,
    input  logic                i_job_pop
);
    localparam int PtrW = $clog2(selt_pkg::QDepth);

    selt_pkg::t_job r_q [selt_pkg::QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt;
    logic            push;
    selt_pkg::t_job  job_in;

    always_comb begin
        job_in.cmd    = selt_pkg::t_cmd'(req.command);
        job_in.tx     = req.tx_id[selt_pkg::TxW-1:0];
        job_in.res    = req.resource_id[selt_pkg::ResW-1:0];
        job_in.tx_ok  = {28'd0, req.tx_id} < selt_pkg::NumTx;
        job_in.res_ok = {26'd0, req.resource_id} < selt_pkg::NumRes;
    end

    assign req.ready   = r_cnt != (PtrW+1)'(selt_pkg::QDepth);
    assign push        = req.valid && req.ready;
    assign o_job_valid = r_cnt != '0;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_job_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(i_job_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW+1)'(selt_pkg::QDepth)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_pop |-> o_job_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_job_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("count slip");
endmodule

// ----- hdl/selt_back.sv -----
// Back end: lock table memory, acquire, release and query sequencer.
module selt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  selt_pkg::t_job i_job,
    output logic           o_job_pop,
    selt_rsp_if.source     rsp
);
    localparam int RW = selt_pkg::ResW;
    localparam int NT = selt_pkg::NumTx;

    selt_pkg::t_state r_state, n_state;
    selt_pkg::t_job   r_job, n_job;
    logic [RW:0]      r_addr, n_addr;
    logic [RW-1:0]    r_wa, n_wa;
    logic             r_wv, n_wv;
    logic [NT-1:0]    r_acc, n_acc;
    logic [1:0]       r_st, n_st;

    logic                  we;
    logic [RW-1:0]         waddr, raddr;
    selt_pkg::t_entry      wdata, rd, ent;
    logic [NT-1:0]         me;
    logic                  other_excl, blocked;

    selt_ram #(.Width(selt_pkg::EntW), .Depth(selt_pkg::NumRes)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    assign me = NT'(1) << r_job.tx;
    assign other_excl = rd.excl_valid && rd.excl_owner != r_job.tx;
    assign blocked = other_excl || (r_job.cmd == selt_pkg::CMD_EXCL &&
                     rd.shared_set != '0 && rd.shared_set != me);
    assign raddr = r_addr[RW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            selt_pkg::S_INIT:  if (r_addr == (RW+1)'(selt_pkg::NumRes - 1))
                                   n_state = selt_pkg::S_IDLE;
            selt_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    if ((i_job.cmd == selt_pkg::CMD_SHARED ||
                         i_job.cmd == selt_pkg::CMD_EXCL) &&
                        !(i_job.tx_ok && i_job.res_ok))
                        n_state = selt_pkg::S_OUT;
                    else if (i_job.cmd == selt_pkg::CMD_SHARED ||
                             i_job.cmd == selt_pkg::CMD_EXCL)
                        n_state = selt_pkg::S_READ;
                    else if (!i_job.tx_ok)
                        n_state = selt_pkg::S_OUT;
                    else
                        n_state = selt_pkg::S_SWEEP;
                end
            end
            selt_pkg::S_READ:  n_state = selt_pkg::S_ACQ;
            selt_pkg::S_ACQ:   n_state = selt_pkg::S_OUT;
            selt_pkg::S_SWEEP: if (r_addr == (RW+1)'(selt_pkg::NumRes))
                                   n_state = selt_pkg::S_OUT;
            selt_pkg::S_OUT:   if (rsp.ready) n_state = selt_pkg::S_IDLE;
            default:           n_state = selt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_job = r_job;
        n_addr = r_addr;
        n_wa = r_wa;
        n_wv = 1'b0;
        n_acc = r_acc;
        n_st = r_st;
        we = 1'b0;
        waddr = r_wa;
        wdata = '0;
        ent = rd;
        o_job_pop = 1'b0;
        unique case (r_state)
            selt_pkg::S_INIT: begin
                we = 1'b1;
                waddr = r_addr[RW-1:0];
                n_addr = r_addr + 1'b1;
            end
            selt_pkg::S_IDLE: begin
                o_job_pop = i_job_valid;
                n_job = i_job;
                n_acc = '0;
                n_st = (i_job.cmd == selt_pkg::CMD_RELEASE) ? selt_pkg::ST_RELEASED :
                       (i_job.cmd == selt_pkg::CMD_QUERY) ? selt_pkg::ST_QUERY :
                       selt_pkg::ST_WAIT;
                n_addr = (i_job.cmd == selt_pkg::CMD_SHARED ||
                          i_job.cmd == selt_pkg::CMD_EXCL) ?
                         {1'b0, i_job.res} : '0;
            end
            selt_pkg::S_READ: ;
            selt_pkg::S_ACQ: begin
                we = 1'b1;
                waddr = r_job.res;
                if (blocked) begin
                    ent.waiter_set = rd.waiter_set | me;
                    n_st = selt_pkg::ST_WAIT;
                end else begin
                    ent.waiter_set = rd.waiter_set & ~me;
                    n_st = selt_pkg::ST_GRANTED;
                    if (r_job.cmd == selt_pkg::CMD_EXCL) begin
                        ent.excl_valid = 1'b1;
                        ent.excl_owner = r_job.tx;
                        ent.shared_set = '0;
                    end else begin
                        ent.shared_set = rd.shared_set | me;
                    end
                end
                wdata = ent;
            end
            selt_pkg::S_SWEEP: begin
                // read of address r_addr issued; data for r_wa valid when r_wv
                if (r_addr != (RW+1)'(selt_pkg::NumRes)) begin
                    n_addr = r_addr + 1'b1;
                    n_wa = r_addr[RW-1:0];
                    n_wv = 1'b1;
                end
                if (r_wv) begin
                    if (r_job.cmd == selt_pkg::CMD_RELEASE) begin
                        ent.shared_set = rd.shared_set & ~me;
                        ent.waiter_set = rd.waiter_set & ~me;
                        if (rd.excl_valid && rd.excl_owner == r_job.tx) begin
                            ent.excl_valid = 1'b0;
                            ent.excl_owner = '0;
                        end
                        we = 1'b1;
                        wdata = ent;
                    end else if ((rd.waiter_set & me) != '0) begin
                        n_acc = rd.excl_valid ? (r_acc | (NT'(1) << rd.excl_owner)) :
                                (r_acc | (rd.shared_set & ~me));
                    end
                end
            end
            selt_pkg::S_OUT: ;
            default: ;
        endcase
    end

    assign rsp.valid = r_state == selt_pkg::S_OUT;
    assign rsp.status = r_st;
    assign rsp.wait_for_set = 16'(r_acc);

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_wa <= n_wa;
        r_acc <= n_acc;
        r_st <= n_st;
        if (!i_rst_n) begin
            r_state <= selt_pkg::S_INIT;
            r_addr <= '0;
            r_wv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_wv <= n_wv;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_state == selt_pkg::S_IDLE) else $error("pop while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.status != selt_pkg::ST_QUERY) |-> rsp.wait_for_set == '0)
        else $error("nonzero set on non-query");
endmodule

// ----- hdl/shared_exclusive_lock_table_unit.sv -----
// Top level: shared/exclusive lock table unit.
// After reset the table is cleared entry by entry, during which the sequencer
// starts no job, though the queue still takes requests. An acquire does one
// table read, one write and one response; release-all and query sweep every
// resource entry of the table memory. A two-entry request queue lets new
// requests be taken while the table sequencer works.
module shared_exclusive_lock_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    selt_req_if.sink   req,
    selt_rsp_if.source rsp
);
    logic            job_valid;
    logic            job_pop;
    selt_pkg::t_job  job;

    selt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req),
        .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    selt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid),
        .i_job(job), .o_job_pop(job_pop), .rsp(rsp)
    );
endmodule
